FILE: design/bmi_pkg.sv
// Shared types and constants for the bilinear map interpolation block.
package bmi_pkg;

	localparam int AXIS_W = 16;
	localparam int VAL_W = 16;
	localparam int IDX_W = 4;
	localparam int GRID = 16;
	localparam int CELL_AW = 2 * IDX_W;
	localparam int SCAN_CNT_W = IDX_W + 1;
	// Interpolated row values stay well inside 34 bits; two spare bits of margin.
	localparam int LV_W = 36;
	localparam int PROD_W = LV_W + AXIS_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int DIV_CNT_W = 6;

	localparam logic [1:0] MODE_CELL = 2'd0;
	localparam logic [1:0] MODE_XBP = 2'd1;
	localparam logic [1:0] MODE_ZBP = 2'd2;
	localparam logic [1:0] MODE_LOOKUP = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] row;
		logic [3:0] col;
		logic [15:0] write_value;
		logic [15:0] x_query;
		logic [15:0] z_query;
	} bmi_req_t;

	typedef struct packed {
		logic signed [15:0] result;
		logic saturated;
		logic bad_axis;
	} bmi_rsp_t;

	typedef struct packed {
		logic start;
		logic [PROD_W-1:0] dividend;
		logic [AXIS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: design/bilinear_map_interpolation_16x16.sv
// Top level of the 16x16 bilinear map interpolation block.
//
// The req channel carries one beat per item: a write of a map cell, of an x
// breakpoint or of a z breakpoint, or a lookup at (x_query, z_query). Every
// beat produces exactly one beat on the rsp channel; writes answer with zero.
// The response to a write appears in the next cycle.
// A lookup runs from its accepted beat to its response beat in these steps:
// a scan of both breakpoint memories side by side, a read of the four
// bounding cells from the map memory, three linear steps (setup, multiply,
// divider start, the shared bit-serial divider for its 52 quotient bits,
// add) and a load of the output register.
// A step across an equal breakpoint pair skips the multiply and the divider.
// Only one lookup is in flight; req_stall is high while it runs.
// The response sits in an output register; while the receiver holds
// rsp_stall, that beat is kept and a new req beat is taken only once the
// register can be refilled. Reset clears the control state and the output
// valid; the memories keep no reset value and must be written before use.
module bilinear_map_interpolation_16x16 (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input bmi_pkg::bmi_req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output bmi_pkg::bmi_rsp_t rsp
);
	import bmi_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SCAN = 4'd1;
	localparam logic [3:0] ST_CELL = 4'd2;
	localparam logic [3:0] ST_LSET = 4'd3;
	localparam logic [3:0] ST_LMUL = 4'd4;
	localparam logic [3:0] ST_LSTART = 4'd5;
	localparam logic [3:0] ST_LDIV = 4'd6;
	localparam logic [3:0] ST_LADD = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [VAL_W-1:0] map_mem [0:GRID*GRID-1];
	logic [AXIS_W-1:0] xbp_mem [0:GRID-1];
	logic [AXIS_W-1:0] zbp_mem [0:GRID-1];
	logic [VAL_W-1:0] cell_rd;
	logic [AXIS_W-1:0] xbp_rd;
	logic [AXIS_W-1:0] zbp_rd;
	logic [CELL_AW-1:0] cell_ra;
	logic [IDX_W-1:0] bp_ra;

	logic [3:0] state_q;
	logic [SCAN_CNT_W-1:0] cnt_q;
	logic [1:0] step_q;
	logic out_valid_q;
	bmi_rsp_t out_q;

	logic [AXIS_W-1:0] xq_q, zq_q;
	logic xfound_q, zfound_q;
	logic [AXIS_W-1:0] xprev_q, zprev_q;
	logic [AXIS_W-1:0] xa_q, xb_q, za_q, zb_q;
	logic [IDX_W-1:0] j_q, i_q;
	logic [VAL_W-1:0] cell_q [0:3];
	logic signed [LV_W-1:0] y0_q, y1_q, v0_q;
	logic [LV_W-1:0] dv_mag_q;
	logic [AXIS_W-1:0] dq_mag_q, db_mag_q;
	logic neg_q, eq_q, bad_q;
	logic [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0] r_q;

	logic accept;
	logic out_free;
	logic out_load;
	logic [IDX_W-1:0] cmp_k;
	logic [IDX_W-1:0] prev_i, prev_j;

	logic signed [LV_W-1:0] v0_c, v1_c;
	logic [AXIS_W-1:0] b0_c, b1_c, q_c;
	logic signed [LV_W:0] dv_c;
	logic signed [AXIS_W:0] dq_c, db_c;
	logic signed [SUM_W-1:0] qs_c, sum_c;
	logic signed [SUM_W-1:0] hi_lim, lo_lim;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign out_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign accept = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	// The output register is loaded by a write beat or by a finished lookup.
	assign out_load = (accept && req.mode != MODE_LOOKUP) || (state_q == ST_DONE && out_free);

	assign cmp_k = IDX_W'(cnt_q - 1'b1);
	assign prev_i = i_q - 1'b1;
	assign prev_j = j_q - 1'b1;
	assign bp_ra = cnt_q[IDX_W-1:0];
	assign cell_ra = {cnt_q[1] ? i_q : prev_i, cnt_q[0] ? j_q : prev_j};

	// Map memory: written by cell beats, read during the cell fetch.
	always_ff @(posedge clk) begin
		if (accept && req.mode == MODE_CELL)
			map_mem[{req.row, req.col}] <= req.write_value;
		cell_rd <= map_mem[cell_ra];
	end

	// Breakpoint memories: written by axis beats, read during the scan.
	always_ff @(posedge clk) begin
		if (accept && req.mode == MODE_XBP)
			xbp_mem[req.col] <= req.write_value;
		if (accept && req.mode == MODE_ZBP)
			zbp_mem[req.row] <= req.write_value;
		xbp_rd <= xbp_mem[bp_ra];
		zbp_rd <= zbp_mem[bp_ra];
	end

	// Operand selection for the current linear step.
	always_comb begin
		case (step_q)
			2'd0: begin
				v0_c = LV_W'(signed'(cell_q[0]));
				v1_c = LV_W'(signed'(cell_q[1]));
			end
			2'd1: begin
				v0_c = LV_W'(signed'(cell_q[2]));
				v1_c = LV_W'(signed'(cell_q[3]));
			end
			default: begin
				v0_c = y0_q;
				v1_c = y1_q;
			end
		endcase
		b0_c = (step_q == 2'd2) ? za_q : xa_q;
		b1_c = (step_q == 2'd2) ? zb_q : xb_q;
		q_c = (step_q == 2'd2) ? zq_q : xq_q;
		dv_c = (LV_W + 1)'(v1_c) - (LV_W + 1)'(v0_c);
		dq_c = signed'({1'b0, q_c}) - signed'({1'b0, b0_c});
		db_c = signed'({1'b0, b1_c}) - signed'({1'b0, b0_c});
	end

	// Apply the sign to the quotient and add it to the lower node; an equal breakpoint pair passes the lower node alone.
	always_comb begin
		qs_c = neg_q ? -signed'(SUM_W'(div_rsp.quotient)) : signed'(SUM_W'(div_rsp.quotient));
		sum_c = eq_q ? SUM_W'(v0_q) : SUM_W'(v0_q) + qs_c;
		hi_lim = SUM_W'((1 <<< (VAL_W - 1)) - 1);
		lo_lim = -hi_lim - 1;
	end

	assign div_req.start = (state_q == ST_LSTART);
	assign div_req.dividend = prod_q;
	assign div_req.divisor = db_mag_q;

	bmi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// Sequencer state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp_valid && !rsp_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.mode == MODE_LOOKUP) begin
						state_q <= ST_SCAN;
						cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == SCAN_CNT_W'(GRID)) begin
						state_q <= ST_CELL;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CELL: begin
					if (cnt_q == SCAN_CNT_W'(4)) begin
						state_q <= ST_LSET;
						step_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LSET: begin
					state_q <= (db_c == '0) ? ST_LADD : ST_LMUL;
				end
				ST_LMUL: state_q <= ST_LSTART;
				ST_LSTART: state_q <= ST_LDIV;
				ST_LDIV: begin
					if (div_rsp.done)
						state_q <= ST_LADD;
				end
				ST_LADD: begin
					if (step_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
						state_q <= ST_LSET;
					end
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers for the scan, cell fetch and linear steps.
	always_ff @(posedge clk) begin
		if (accept && state_q == ST_IDLE) begin
			xq_q <= req.x_query;
			zq_q <= req.z_query;
			xfound_q <= 1'b0;
			zfound_q <= 1'b0;
			bad_q <= 1'b0;
			if (req.mode != MODE_LOOKUP)
				out_q <= '0;
		end

		// Scan: data of index cnt-1 arrives while index cnt is addressed.
		if (state_q == ST_SCAN && cnt_q != '0) begin
			xprev_q <= xbp_rd;
			zprev_q <= zbp_rd;
			if (cmp_k != '0) begin
				if (!xfound_q && (xq_q <= xbp_rd || cmp_k == IDX_W'(GRID - 1))) begin
					xfound_q <= 1'b1;
					j_q <= cmp_k;
					xa_q <= xprev_q;
					xb_q <= xbp_rd;
				end
				if (!zfound_q && (zq_q <= zbp_rd || cmp_k == IDX_W'(GRID - 1))) begin
					zfound_q <= 1'b1;
					i_q <= cmp_k;
					za_q <= zprev_q;
					zb_q <= zbp_rd;
				end
			end
		end

		// Cell fetch: four corners in the order of the read addresses.
		if (state_q == ST_CELL && cnt_q != '0)
			cell_q[cmp_k[1:0]] <= cell_rd;

		if (state_q == ST_LSET) begin
			v0_q <= v0_c;
			dv_mag_q <= LV_W'(dv_c[LV_W] ? -dv_c : dv_c);
			dq_mag_q <= AXIS_W'(dq_c[AXIS_W] ? -dq_c : dq_c);
			db_mag_q <= AXIS_W'(db_c[AXIS_W] ? -db_c : db_c);
			neg_q <= dv_c[LV_W] ^ dq_c[AXIS_W] ^ db_c[AXIS_W];
			eq_q <= (db_c == '0);
			if (db_c == '0)
				bad_q <= 1'b1;
		end

		if (state_q == ST_LMUL)
			prod_q <= dv_mag_q * dq_mag_q;

		if (state_q == ST_LADD) begin
			case (step_q)
				2'd0: y0_q <= LV_W'(sum_c);
				2'd1: y1_q <= LV_W'(sum_c);
				default: r_q <= sum_c;
			endcase
		end

		// Saturate the final value into the response register.
		if (state_q == ST_DONE && out_free) begin
			out_q.bad_axis <= bad_q;
			if (r_q > hi_lim) begin
				out_q.result <= VAL_W'(hi_lim);
				out_q.saturated <= 1'b1;
			end else if (r_q < lo_lim) begin
				out_q.result <= VAL_W'(lo_lim);
				out_q.saturated <= 1'b1;
			end else begin
				out_q.result <= VAL_W'(r_q);
				out_q.saturated <= 1'b0;
			end
		end
	end

endmodule

FILE: design/bmi_div.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module bmi_div (
	input logic clk,
	input logic arst_n,
	input bmi_pkg::div_req_t req,
	output bmi_pkg::div_rsp_t rsp
);
	import bmi_pkg::*;

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0] quo_q;
	logic [AXIS_W-1:0] rem_q;
	logic [AXIS_W-1:0] den_q;
	logic [AXIS_W:0] trial;
	logic [AXIS_W:0] diff;
	logic ge;

	// Shift in the next dividend bit and try a subtraction.
	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		diff = trial - {1'b0, den_q};
		ge = trial >= {1'b0, den_q};
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= DIV_CNT_W'(PROD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], ge};
			rem_q <= ge ? diff[AXIS_W-1:0] : trial[AXIS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: design/bmi_check.sv
// Port-level checks for the bilinear map interpolation block, bound to the top level.
module bmi_check (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input bmi_pkg::bmi_req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input bmi_pkg::bmi_rsp_t rsp
);
	import bmi_pkg::*;

	// A held response beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A write beat answers with an all-zero response in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.mode != MODE_LOOKUP |=>
		rsp_valid && rsp.result == 16'sd0 && !rsp.saturated && !rsp.bad_axis)
		else $error("write beat gave a wrong response");

	// A lookup beat holds off further requests while it runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.mode == MODE_LOOKUP |=> req_stall)
		else $error("request taken during a lookup");

	// A clamped result sits at one of the range limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.saturated |->
		rsp.result == 16'sh7fff || rsp.result == -16'sh8000)
		else $error("saturated result not at a limit");

endmodule

bind bilinear_map_interpolation_16x16 bmi_check u_bmi_check (.*);
